// ----- rtl/tdes_pkg.sv -----
// Shared types and constants of the decaying event score block.
`timescale 1ns / 1ps
package tdes_pkg;

  localparam int unsigned SCORE_W  = 48;
  localparam int unsigned TS_W     = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned FACTOR_W = 16;
  localparam int unsigned HI_W     = 32;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'h8000;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PMUL = 8'b0000_0010,
    S_BSQ  = 8'b0000_0100,
    S_DLO  = 8'b0000_1000,
    S_DHI  = 8'b0001_0000,
    S_ADD  = 8'b0010_0000,
    S_OLO  = 8'b0100_0000,
    S_OHI  = 8'b1000_0000
  } state_e;

  typedef enum logic [1:0] {
    MUL_PB = 2'd0,
    MUL_BB = 2'd1,
    MUL_LO = 2'd2,
    MUL_HI = 2'd3
  } mul_op_e;

endpackage

// ----- rtl/timestamped_decaying_event_score.sv -----
// Top level of the timestamped decaying event score: sequencer, state and handshakes.
`timescale 1ns / 1ps
// Each accepted word is worked on alone by one shared multiplier under a
// small sequencer, and in_ready_o is low until it is done. A word whose
// timestamp does not move forward skips the decay; for a word with a
// positive age, square-and-multiply spends one multiply on the running
// power and one on squaring the base per age bit and stops after the
// top set bit. The result waits in an output register, so the next word is
// taken while the previous result is still unclaimed; the sequencer holds
// its last step only if a new result is ready before the old one has been
// taken. Writes of decay_factor are taken at any time and must only happen
// while idle.
module timestamped_decaying_event_score #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tdes_pkg::FACTOR_W-1:0]  decay_factor_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [tdes_pkg::TS_W-1:0]      timestamp_i,
  input  logic [tdes_pkg::CNT_W-1:0]     event_count_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tdes_pkg::SCORE_W-1:0]   score_o
);
  import tdes_pkg::*;

  localparam int unsigned PW  = FRAC_BITS + 1;
  localparam int unsigned SB  = HI_W + FRAC_BITS;
  localparam int unsigned SHL = (FRAC_BITS >= FACTOR_W) ? FRAC_BITS - FACTOR_W : 0;
  localparam int unsigned SHR = (FRAC_BITS < FACTOR_W) ? FACTOR_W - FRAC_BITS : 0;
  localparam logic [PW-1:0] UNITY = PW'(1) << FRAC_BITS;

  state_e                state_q, state_d;
  logic [FACTOR_W-1:0]   factor_q, factor_d;
  logic [SB-1:0]         acc_q, acc_d;
  logic [TIME_BITS-1:0]  last_q, last_d;
  logic [TIME_BITS-1:0]  age_q, age_d;
  logic [PW-1:0]         p_q, p_d;
  logic [PW-1:0]         b_q, b_d;
  logic [PW-1:0]         tmp_q, tmp_d;
  logic                  mode_q, mode_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [SCORE_W-1:0]    score_q, score_d;
  logic                  out_valid_q, out_valid_d;

  logic [TIME_BITS-1:0]  t_in;
  logic [PW-1:0]         fq;
  logic [SB:0]           sum;
  mul_op_e               mul_op;
  logic [PW-1:0]         mul_frac;
  logic [SB-1:0]         mul_wide;
  logic                  in_fire;
  logic                  slot_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign score_o     = score_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  assign t_in = TIME_BITS'(timestamp_i);
  assign fq   = PW'((32'(factor_q) << SHL) >> SHR);
  assign sum  = {1'b0, acc_q} + (SB + 1)'({cnt_q, {FRAC_BITS{1'b0}}});

  always_comb begin
    case (state_q)
      S_PMUL:       mul_op = MUL_PB;
      S_BSQ:        mul_op = MUL_BB;
      S_DLO, S_OLO: mul_op = MUL_LO;
      default:      mul_op = MUL_HI;
    endcase
  end

  tdes_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .op_i   (mul_op),
    .p_i    (p_q),
    .b_i    (b_q),
    .v_i    (acc_q),
    .tmp_i  (tmp_q),
    .frac_o (mul_frac),
    .wide_o (mul_wide)
  );

  always_comb begin
    state_d     = state_q;
    factor_d    = factor_q;
    acc_d       = acc_q;
    last_d      = last_q;
    age_d       = age_q;
    p_d         = p_q;
    b_d         = b_q;
    tmp_d       = tmp_q;
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    score_d     = score_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_valid_i) begin
      factor_d = decay_factor_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mode_d = mode_i;
          cnt_d  = event_count_i;
          p_d    = UNITY;
          b_d    = fq;
          if (t_in > last_q) begin
            age_d   = t_in - last_q;
            last_d  = t_in;
            state_d = S_PMUL;
          end else begin
            state_d = S_ADD;
          end
        end
      end
      S_PMUL: begin
        if (age_q[0]) begin
          p_d = mul_frac;
        end
        state_d = S_BSQ;
      end
      S_BSQ: begin
        b_d   = mul_frac;
        age_d = age_q >> 1;
        if ((age_q >> 1) == '0) begin
          state_d = S_DLO;
        end else begin
          state_d = S_PMUL;
        end
      end
      S_DLO: begin
        tmp_d   = mul_frac;
        state_d = S_DHI;
      end
      S_DHI: begin
        acc_d   = mul_wide;
        state_d = S_ADD;
      end
      S_ADD: begin
        if (mode_q) begin
          acc_d = sum[SB] ? {SB{1'b1}} : sum[SB-1:0];
        end
        p_d     = UNITY - fq;
        state_d = S_OLO;
      end
      S_OLO: begin
        tmp_d   = mul_frac;
        state_d = S_OHI;
      end
      S_OHI: begin
        if (slot_free) begin
          score_d     = SCORE_W'(mul_wide);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      factor_q    <= FACTOR_RESET;
      acc_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      factor_q    <= factor_d;
      acc_q       <= acc_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    age_q   <= age_d;
    p_q     <= p_d;
    b_q     <= b_d;
    tmp_q   <= tmp_d;
    mode_q  <= mode_d;
    cnt_q   <= cnt_d;
    score_q <= score_d;
  end

endmodule

// ----- rtl/tdes_mul.sv -----
// Shared fixed-point multiplier with operand select, truncation and merge add.
`timescale 1ns / 1ps
module tdes_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  tdes_pkg::mul_op_e          op_i,
  input  logic [FRAC_BITS:0]         p_i,
  input  logic [FRAC_BITS:0]         b_i,
  input  logic [31+FRAC_BITS:0]      v_i,
  input  logic [FRAC_BITS:0]         tmp_i,
  output logic [FRAC_BITS:0]         frac_o,
  output logic [31+FRAC_BITS:0]      wide_o
);
  import tdes_pkg::*;

  localparam int unsigned PW     = FRAC_BITS + 1;
  localparam int unsigned SB     = HI_W + FRAC_BITS;
  localparam int unsigned PROD_W = HI_W + PW;

  logic [HI_W-1:0]   a_op;
  logic [PW-1:0]     b_op;
  logic [PROD_W-1:0] prod;

  always_comb begin
    case (op_i)
      MUL_PB: begin
        a_op = HI_W'(p_i);
        b_op = b_i;
      end
      MUL_BB: begin
        a_op = HI_W'(b_i);
        b_op = b_i;
      end
      MUL_LO: begin
        a_op = HI_W'(v_i[FRAC_BITS-1:0]);
        b_op = p_i;
      end
      MUL_HI: begin
        a_op = v_i[SB-1:FRAC_BITS];
        b_op = p_i;
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign prod   = PROD_W'(a_op) * PROD_W'(b_op);
  assign frac_o = PW'(prod >> FRAC_BITS);
  assign wide_o = SB'(prod + PROD_W'(tmp_i));

endmodule

// ----- test/tdes_score_checker.sv -----
// Checker for the decaying event score: predicts each score word and compares it.
`timescale 1ns / 1ps
module tdes_score_checker
  import tdes_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [FACTOR_W-1:0]  decay_factor_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 mode_i,
  input  logic [TS_W-1:0]      timestamp_i,
  input  logic [CNT_W-1:0]     event_count_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [SCORE_W-1:0]   score_i,
  output int unsigned          errors_o,
  output int unsigned          pending_o
);

  localparam int unsigned FRAC      = 16;
  localparam logic [63:0] ONE_Q     = 64'd1 << FRAC;
  localparam logic [63:0] SCORE_TOP = (64'd1 << SCORE_W) - 64'd1;
  localparam int unsigned SHOW_MAX  = 40;

  logic [FACTOR_W-1:0] decay_mult;
  logic [SCORE_W-1:0]  score_acc;
  logic [TS_W-1:0]     stamp_last;
  logic [SCORE_W-1:0]  score_due[$];
  int unsigned         n_err;

  function automatic logic [63:0] q_mul(logic [63:0] v, logic [63:0] p);
    return (v >> FRAC) * p + (((v & (ONE_Q - 64'd1)) * p) >> FRAC);
  endfunction

  function automatic logic [63:0] decay_gain(logic [TS_W-1:0] age, logic [FACTOR_W-1:0] f);
    logic [63:0] p;
    logic [63:0] b;
    int          i;
    p = ONE_Q;
    b = {48'd0, f};
    for (i = 0; i < TS_W; i++) begin
      if (age[i]) begin
        p = (p * b) >> FRAC;
      end
      b = (b * b) >> FRAC;
    end
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0]        acc;
    logic [63:0]        add;
    logic [63:0]        outv;
    logic [SCORE_W-1:0] want;
    if (!rst_ni) begin
      decay_mult = FACTOR_RESET;
      score_acc  = '0;
      stamp_last = '0;
      score_due.delete();
      n_err      = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        decay_mult = decay_factor_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (score_due.size() == 0) begin
          n_err++;
          if (n_err <= SHOW_MAX) begin
            $display("%0t: score word with none expected, expected none actual %h",
                     $time, score_i);
          end
        end else begin
          want = score_due.pop_front();
          if (want !== score_i) begin
            n_err++;
            if (n_err <= SHOW_MAX) begin
              $display("%0t: score mismatch, expected %h actual %h", $time, want, score_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        acc = {16'd0, score_acc};
        if (timestamp_i > stamp_last) begin
          acc = q_mul(acc, decay_gain(timestamp_i - stamp_last, decay_mult));
          stamp_last = timestamp_i;
        end
        if (mode_i) begin
          add = {48'd0, event_count_i} << FRAC;
          if (add > SCORE_TOP - acc) begin
            acc = SCORE_TOP;
          end else begin
            acc = acc + add;
          end
        end
        score_acc = acc[SCORE_W-1:0];
        outv = q_mul(acc, ONE_Q - {48'd0, decay_mult});
        score_due.push_back(outv[SCORE_W-1:0]);
      end
      errors_o  <= n_err;
      pending_o <= score_due.size();
    end
  end

endmodule

// ----- test/tb.sv -----
// Testbench top for the decaying event score: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
  import tdes_pkg::*;

  localparam int unsigned LIMIT       = 4_000_000;
  localparam int unsigned PHASE_WORDS = 145;
  localparam int unsigned FILL_WORDS  = 20;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [FACTOR_W-1:0] decay_factor;
  logic                in_valid;
  logic                in_ready;
  logic                mode;
  logic [TS_W-1:0]     timestamp;
  logic [CNT_W-1:0]    event_count;
  logic                out_valid;
  logic                out_ready;
  logic [SCORE_W-1:0]  score;
  int unsigned         errors;
  int unsigned         pending;
  int unsigned         cycles = 0;

  logic [TS_W-1:0]     now_ts;
  bit                  gaps_on = 1'b1;
  bit                  sink_quiet = 1'b0;
  bit                  sink_hold = 1'b0;
  logic [FACTOR_W-1:0] mults[8];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  timestamped_decaying_event_score i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .decay_factor_i (decay_factor),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .timestamp_i    (timestamp),
    .event_count_i  (event_count),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .score_o        (score)
  );

  tdes_score_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .decay_factor_i (decay_factor),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .mode_i         (mode),
    .timestamp_i    (timestamp),
    .event_count_i  (event_count),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .score_i        (score),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic push_word(input logic m, input logic [TS_W-1:0] ts,
                           input logic [CNT_W-1:0] cnt);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    timestamp   <= ts;
    event_count <= cnt;
    do @(posedge clk_i); while (!in_ready);
    if (ts > now_ts) begin
      now_ts = ts;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_factor(input logic [FACTOR_W-1:0] f);
    cfg_valid    <= 1'b1;
    decay_factor <= f;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_word();
    logic [TS_W-1:0]  ts;
    logic [TS_W:0]    ahead;
    logic [CNT_W-1:0] cnt;
    int unsigned      sel;
    int unsigned      nb;
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      if ($urandom_range(0, 49) == 0) begin
        nb = $urandom_range(25, 30);
      end else if ($urandom_range(0, 9) == 0) begin
        nb = $urandom_range(11, 24);
      end else begin
        nb = $urandom_range(0, 10);
      end
      ahead = {1'b0, now_ts} + ((nb == 0) ? 33'd0 : {1'b0, $urandom() >> (32 - nb)});
      ts = ahead[TS_W] ? $urandom_range(0, now_ts) : ahead[TS_W-1:0];
    end else if (sel < 85) begin
      ts = now_ts;
    end else begin
      ts = $urandom_range(0, now_ts);
    end
    sel = $urandom_range(0, 9);
    cnt = (sel == 0) ? '0 : (sel == 1) ? '1 : CNT_W'($urandom_range(0, 65535));
    push_word(1'($urandom_range(0, 1)), ts, cnt);
  endtask

  initial begin : sink
    out_ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold) begin
        sink_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end else if (!sink_quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    cfg_valid    <= 1'b0;
    decay_factor <= '0;
    in_valid     <= 1'b0;
    mode         <= 1'b0;
    timestamp    <= '0;
    event_count  <= '0;
    now_ts = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_word(1'b0, 32'h0000_0000, 16'hFFFF);
    push_word(1'b1, 32'h0000_0000, 16'hFFFF);
    push_word(1'b1, 32'h0000_0000, 16'h0000);
    push_word(1'b0, 32'h0000_0001, 16'h0000);
    push_word(1'b1, 32'h0000_0003, 16'h0001);
    push_word(1'b0, 32'h0000_0002, 16'h0000);
    push_word(1'b1, 32'h0000_0002, 16'h0005);
    push_word(1'b1, 32'h0000_0003, 16'hFFFF);
    push_word(1'b0, 32'h0000_0013, 16'h0000);
    push_word(1'b1, 32'h8000_0013, 16'h8000);
    push_word(1'b0, 32'h8000_0014, 16'h0000);
    drain();
    set_factor(16'h0000);
    push_word(1'b1, 32'h8000_0014, 16'hFFFF);
    push_word(1'b0, 32'h8000_0014, 16'h0000);
    push_word(1'b0, 32'h8000_0020, 16'h0000);
    push_word(1'b1, 32'h8000_0021, 16'h1234);
    push_word(1'b0, 32'h8000_0010, 16'h0000);
    drain();
    set_factor(16'hFFFF);
    push_word(1'b1, 32'h8000_0030, 16'hFFFF);
    push_word(1'b0, 32'h8000_0031, 16'h0000);
    push_word(1'b0, 32'h8000_4031, 16'h0000);
    push_word(1'b1, 32'h8000_4031, 16'hFFFF);

    mults = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 16'h0000, 16'h4000, 16'h0000, 16'hF000};
    mults[4] = FACTOR_W'($urandom_range(0, 65535));
    mults[6] = FACTOR_W'($urandom_range(0, 65535));
    foreach (mults[k]) begin
      drain();
      set_factor(mults[k]);
      if (k == 3) begin
        sink_hold = 1'b1;
      end
      repeat (PHASE_WORDS) random_word();
    end

    // hold time still for the fill words: no decay, so the score only grows until time jumps to the top
    drain();
    gaps_on    = 1'b0;
    sink_quiet = 1'b1;
    set_factor(16'hFFFF);
    repeat (FILL_WORDS) begin
      push_word(1'b1, $urandom_range(0, now_ts), CNT_W'($urandom_range(65000, 65535)));
    end
    push_word(1'b1, now_ts, 16'hFFFF);
    push_word(1'b0, now_ts, 16'h0000);
    push_word(1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    push_word(1'b0, 32'hFFFF_FFFF, 16'h0000);
    push_word(1'b1, 32'h0000_0000, 16'h0001);
    drain();

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tdes_pkg.sv
rtl/tdes_mul.sv
rtl/timestamped_decaying_event_score.sv
test/tdes_score_checker.sv
test/tb.sv
